// File: rtl/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg
// shared types and constants of the split segment timer
// ----------------------------------------------------------------------------
package sst_pkg;

    localparam int unsigned SST_MAX_SEGMENTS = 16;
    localparam int unsigned ELAPSED_W        = 16;
    localparam logic [ELAPSED_W-1:0] ELAPSED_LIMIT = 16'hFFFF;

    // event codes
    localparam logic [1:0] OP_TAP   = 2'd0;
    localparam logic [1:0] OP_HOLD  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_RUNNING = 2'd1,
        MODE_SUMMARY = 2'd2
    } mode_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] now_s;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  segment;
        logic [4:0]  banked_count;
        logic [15:0] elapsed_s;
        logic [4:0]  hours;
        logic [5:0]  minutes;
        logic [5:0]  seconds;
    } out_item_t;

    // first stage of the result path
    typedef struct packed {
        mode_t                mode;
        logic [3:0]           segment;
        logic [4:0]           banked_count;
        logic [ELAPSED_W-1:0] live_s;
    } stage_t;

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
    } hms_t;

endpackage

// File: rtl/split_segment_timer.sv
// ----------------------------------------------------------------------------
// split_segment_timer
// split timer with idle, running and summary modes and banked segment times
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one item per event: op (tap, hold, query)
//   and the current time in seconds. m_valid/m_ready/m_data return one item
//   per input: mode, segment, banked count, elapsed time and its split into
//   hours, minutes and seconds.
//   Timer state and the middle stage are updated at the edge that takes the
//   item; the result register loads from the middle stage whenever the
//   result side can advance (middle stage, then result register).
//   One item per cycle is accepted while the result side keeps up; the rate
//   is set by the state update and the one write plus one registered read
//   of the segment table per item.
//   When m_ready is low the result register holds, the middle stage fills,
//   and s_ready drops only once both are occupied; nothing is lost.
//   Reset returns the timer to idle, segment 0, nothing banked, start time 0.
//   The segment table has no reset; entries are written as segments are
//   banked and only banked entries ever reach the output.
// ----------------------------------------------------------------------------
module split_segment_timer
    import sst_pkg::*;
#(
    parameter int unsigned MAX_SEGMENTS = SST_MAX_SEGMENTS
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int unsigned SegW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int unsigned CntW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [SegW-1:0] SegLast = SegW'(MAX_SEGMENTS - 1);

    // timer state
    mode_t           mode_reg, mode_next;
    logic [SegW-1:0] seg_reg, seg_next;
    logic [CntW-1:0] banked_reg, banked_next;
    logic [31:0]     start_reg, start_next;

    // pipeline
    logic            mid_valid_reg, mid_valid_next;
    stage_t          mid_reg;
    logic [15:0]     rd_data_reg;
    logic            m_valid_reg, m_valid_next;
    out_item_t       out_reg;

    logic            accept;
    logic            advance;
    logic [31:0]     diff;
    logic [15:0]     live_el;
    logic            wr_en;
    logic            restart;
    logic [SegW:0]   seg_inc;
    logic [SegW+3:0] seg_ext;
    logic [CntW+4:0] cnt_ext;
    logic [15:0]     seg_times_mem [MAX_SEGMENTS];
    logic [15:0]     el_sel;
    hms_t            hms;

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = !mid_valid_reg || advance;
    assign accept  = s_valid && s_ready;

    always_comb begin
        diff = s_data.now_s - start_reg;
        if (s_data.now_s <= start_reg) begin
            live_el = '0;
        end else if (diff > 32'(ELAPSED_LIMIT)) begin
            live_el = ELAPSED_LIMIT;
        end else begin
            live_el = diff[15:0];
        end
        seg_inc = {1'b0, seg_reg} + 1'b1;
    end

    // next state
    always_comb begin
        mode_next   = mode_reg;
        seg_next    = seg_reg;
        banked_next = banked_reg;
        start_next  = start_reg;
        case (s_data.op)
            OP_HOLD: begin
                case (mode_reg)
                    MODE_IDLE: begin
                        mode_next   = MODE_RUNNING;
                        seg_next    = '0;
                        banked_next = '0;
                        start_next  = s_data.now_s;
                    end
                    MODE_RUNNING: begin
                        mode_next   = MODE_SUMMARY;
                        seg_next    = '0;
                        banked_next = CntW'(seg_inc);
                    end
                    default: begin
                        mode_next   = MODE_IDLE;
                        seg_next    = '0;
                        banked_next = '0;
                    end
                endcase
            end
            OP_TAP: begin
                if (mode_reg == MODE_RUNNING && seg_reg != SegLast) begin
                    banked_next = CntW'(seg_inc);
                    seg_next    = seg_inc[SegW-1:0];
                    start_next  = s_data.now_s;
                end else if (mode_reg == MODE_SUMMARY) begin
                    // cycle through the banked segments
                    if ((CntW + 1)'(seg_inc) >= (CntW + 1)'(banked_reg)) begin
                        seg_next = '0;
                    end else begin
                        seg_next = seg_inc[SegW-1:0];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // controls derived from the event
    always_comb begin
        wr_en   = 1'b0;
        restart = 1'b0;
        case (s_data.op)
            OP_HOLD: begin
                wr_en   = (mode_reg == MODE_RUNNING);
                restart = (mode_reg == MODE_IDLE);
            end
            OP_TAP: begin
                wr_en   = (mode_reg == MODE_RUNNING) && (seg_reg != SegLast);
                restart = wr_en;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_IDLE;
            seg_reg       <= '0;
            banked_reg    <= '0;
            start_reg     <= '0;
            mid_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (accept) begin
                mode_reg   <= mode_next;
                seg_reg    <= seg_next;
                banked_reg <= banked_next;
                start_reg  <= start_next;
            end
            mid_valid_reg <= mid_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_comb begin
        mid_valid_next = accept || (mid_valid_reg && !advance);
        m_valid_next   = (mid_valid_reg && advance) || (m_valid_reg && !m_ready);
    end

    // segment table: one write, one registered read with write bypass
    always_ff @(posedge aclk) begin
        if (accept && wr_en) begin
            seg_times_mem[seg_reg] <= live_el;
        end
        if (accept) begin
            if (wr_en && seg_reg == seg_next) begin
                rd_data_reg <= live_el;
            end else begin
                rd_data_reg <= seg_times_mem[seg_next];
            end
        end
    end

    always_comb begin
        seg_ext = {4'b0, seg_next};
        cnt_ext = {5'b0, banked_next};
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mid_reg.mode         <= mode_next;
            mid_reg.segment      <= seg_ext[3:0];
            mid_reg.banked_count <= cnt_ext[4:0];
            mid_reg.live_s       <= restart ? '0 : live_el;
        end
    end

    always_comb begin
        case (mid_reg.mode)
            MODE_RUNNING: el_sel = mid_reg.live_s;
            MODE_SUMMARY: el_sel = rd_data_reg;
            default:      el_sel = '0;
        endcase
    end

    sst_hms_split u_hms (
        .elapsed_s (el_sel),
        .hms       (hms)
    );

    always_ff @(posedge aclk) begin
        if (mid_valid_reg && advance) begin
            out_reg.mode         <= mid_reg.mode;
            out_reg.segment      <= mid_reg.segment;
            out_reg.banked_count <= mid_reg.banked_count;
            out_reg.elapsed_s    <= el_sel;
            out_reg.hours        <= hms.hours;
            out_reg.minutes      <= hms.minutes;
            out_reg.seconds      <= hms.seconds;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

// File: rtl/sst_hms_split.sv
// ----------------------------------------------------------------------------
// sst_hms_split
// splits a seconds count into hours, minutes and seconds by constant division
// ----------------------------------------------------------------------------
module sst_hms_split
    import sst_pkg::*;
(
    input  logic [ELAPSED_W-1:0] elapsed_s,
    output hms_t                 hms
);

    // reciprocals: 37283 / 2^27 for 1/3600, 69906 / 2^22 for 1/60,
    // both exact over the whole 16-bit range
    localparam logic [15:0] RECIP_3600 = 16'd37283;
    localparam logic [16:0] RECIP_60   = 17'd69906;

    logic [31:0] prod_h;
    logic [32:0] prod_m;
    logic [4:0]  hours;
    logic [10:0] total_min;
    logic [10:0] hours_x60;
    logic [10:0] min_rem;
    logic [15:0] total_min_x60;
    logic [15:0] sec_rem;

    always_comb begin
        prod_h    = 32'(elapsed_s) * 32'(RECIP_3600);
        prod_m    = 33'(elapsed_s) * 33'(RECIP_60);
        hours     = prod_h[31:27];
        total_min = prod_m[32:22];

        // x60 as x64 - x4
        hours_x60     = (11'(hours) << 6) - (11'(hours) << 2);
        min_rem       = total_min - hours_x60;
        total_min_x60 = (16'(total_min) << 6) - (16'(total_min) << 2);
        sec_rem       = elapsed_s - total_min_x60;

        hms.hours   = hours;
        hms.minutes = min_rem[5:0];
        hms.seconds = sec_rem[5:0];
    end

endmodule
